// ----- hdl/u2a_pkg.sv -----
// ----------------------------------------------------------------------------
// u2a_pkg: shared types and constants
// State encoding, control struct and ASCII constants for the digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package u2a_pkg;

   localparam int unsigned DIGIT_W = 4;

   localparam logic [6:0] ASCII_ZERO     = 7'd48;  // '0'
   localparam logic [6:0] HEX_LETTER_GAP = 7'd7;   // ('A' - 10) - '0'
   localparam logic [3:0] DEC_RADIX      = 4'd10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   // Commands from the sequencer to the digit shifter.
   typedef struct packed {
      logic load;   // take a new value
      logic step;   // one double-dabble step
      logic drop;   // shift the digit register up by one digit
   } shift_ctl_type;

endpackage

`default_nettype wire

// ----- hdl/u2a_digit_shift.sv -----
// ----------------------------------------------------------------------------
// u2a_digit_shift: bit-serial binary to digit shifter
// Double-dabble conversion one bit per step, then digits leave at the top.
// ----------------------------------------------------------------------------
`default_nettype none

module u2a_digit_shift
   import u2a_pkg::*;
#(
   parameter int unsigned EFF_W = 32,
   parameter int unsigned NDIG  = 10
) (
   input  wire logic              clock,
   input  wire shift_ctl_type     ctl,
   input  wire logic              use_hex,
   input  wire logic [EFF_W-1:0]  value,
   output logic      [DIGIT_W-1:0] top_digit
);

   localparam int unsigned BCD_W = NDIG * DIGIT_W;

   logic [EFF_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [BCD_W-1:0] adj;

   // Add 3 to every digit of 5 or more before the shift.
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + 4'd3;
         end else begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      priority if (ctl.load) begin
         bin_in = value;
         // hex digits are the nibbles of the value itself
         bcd_in = use_hex ? {{(BCD_W-EFF_W){1'b0}}, value} : '0;
      end else if (ctl.step) begin
         bin_in = {bin_ff[EFF_W-2:0], 1'b0};
         bcd_in = {adj[BCD_W-2:0], bin_ff[EFF_W-1]};
      end else if (ctl.drop) begin
         bcd_in = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];

endmodule

`default_nettype wire

// ----- hdl/unsigned_to_ascii_digits_core.sv -----
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits_core: unsigned number to ASCII digit stream
// Turns one number into its decimal or upper-case hex digits, MSD first.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one beat carries req_value and req_use_hex (1 = hex).
//   rsp_ channel: one beat per digit, rsp_character in ASCII, rsp_last_digit
//   high on the least significant digit. Leading zeros are dropped; zero
//   gives a single '0'.
//   Timing: one beat at a time. Decimal runs bit-serial double dabble over
//   VALUE_WIDTH (at most 32) bits, one bit per step. Then the suppressed
//   leading zeros are dropped one at a time, emission is entered and one
//   digit is emitted per beat. Hex skips the conversion.
//   req_ready is high only between items. The last digit sits in the output
//   register, so the next request is taken while it waits.
//   A stalled receiver holds rsp_valid and the digit; the digit shifter
//   pauses until the beat is taken.
//   Reset clears the sequencer and the output valid; nothing else is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_to_ascii_digits_core
   import u2a_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_value,
   input  wire logic        req_use_hex,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [6:0]  rsp_character,
   output logic             rsp_last_digit
);

   // Only the low bits up to the field width take part.
   localparam int unsigned EFF_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
   // floor(0.3 * w) + 1 covers ceil(w * log10(2)) for these widths
   localparam int unsigned NDIG  = (EFF_W * 3) / 10 + 1;
   localparam int unsigned CMAX  = (EFF_W > NDIG) ? EFF_W : NDIG;
   localparam int unsigned CNT_W = $clog2(CMAX + 1);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   shift_ctl_type      ctl;
   logic [DIGIT_W-1:0] top_digit;
   logic               rsp_load;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [6:0]         rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               out_free;

   u2a_digit_shift #(
      .EFF_W (EFF_W),
      .NDIG  (NDIG)
   ) u_shift (
      .clock     (clock),
      .ctl       (ctl),
      .use_hex   (req_use_hex),
      .value     (req_value[EFF_W-1:0]),
      .top_digit (top_digit)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and counter.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_use_hex) begin
                  state_in = ST_SKIP;
                  cnt_in   = CNT_W'(NDIG);
               end else begin
                  state_in = ST_CONVERT;
                  cnt_in   = CNT_W'(EFF_W);
               end
            end
         end
         ST_CONVERT: begin
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_SKIP;
               cnt_in   = CNT_W'(NDIG);
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_SKIP: begin
            if (top_digit == '0 && cnt_ff != CNT_W'(1)) begin
               cnt_in = cnt_ff - CNT_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cnt_in = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      ctl       = '0;
      rsp_load  = 1'b0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         ST_CONVERT: ctl.step = 1'b1;
         ST_SKIP:    ctl.drop = (top_digit == '0 && cnt_ff != CNT_W'(1));
         ST_EMIT: begin
            rsp_load = out_free;
            ctl.drop = out_free;
         end
         default: ;
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = (cnt_ff == CNT_W'(1));
         if (top_digit < DEC_RADIX) begin
            rsp_char_in = ASCII_ZERO + {3'b000, top_digit};
         end else begin
            rsp_char_in = ASCII_ZERO + HEX_LETTER_GAP + {3'b000, top_digit};
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_character  = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;

endmodule

`default_nettype wire
